>>> design/pba_pkg.sv
// Shared types and constants for the page bitmap allocator.
// No dependencies.
`default_nettype none
package pba_pkg;
   localparam int PAGE_COUNT = 8192;
   localparam int PAGE_BITS  = 12;
   localparam int PIDX_W     = $clog2(PAGE_COUNT);
   localparam int PCNT_W     = PIDX_W + 1;
   localparam int HDR_BYTES  = 16;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_RESERVE = 2'd2,
      CMD_USAGE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_HEAP_BASE = 2'd0,
      CSR_LOW_PAGE  = 2'd1,
      CSR_USABLE    = 2'd2
   } csr_type;
endpackage
`default_nettype wire

>>> design/pba_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module pba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

>>> design/page_bitmap_allocator.sv
// Page bitmap allocator top level: sequencer over the used-bit and run-length RAMs.
// Depends on pba_pkg and pba_ram.
// Reset: a clearing pass over all PAGE_COUNT (8192) pages zeroes both RAMs; no request is taken.
// An invalid request or an early no-space goes straight to the response; alloc scans
// the window page by page and then marks the run, free reads the run length and clears
// the run, reserve marks its pages and usage walks the window. One request at a time:
// the next is accepted in the cycle after the response is taken.
`default_nettype none
module page_bitmap_allocator
   import pba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: size_bytes[31:0], address[63:32], end_address[95:64]
   input  wire logic [95:0] req_tdata,
   // tuser: command[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: status[1:0], result_address[33:2], window_pages[47:34],
   // busy_pages[61:48], idle_pages[75:62], alloc_calls[107:76],
   // release_calls[139:108], zero fill to 144
   output logic [143:0]     rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_AREAD = 9'b000000100,  // alloc scan: address issued
      S_ACHK  = 9'b000001000,  // alloc scan: data back
      S_MARK  = 9'b000010000,  // write run (alloc or reserve set, free clear)
      S_FRD   = 9'b000100000,  // free: read run length
      S_FCHK  = 9'b001000000,
      S_USE   = 9'b010000000,  // usage count scan
      S_RESP  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]     heap_base_ff;
   logic [PIDX_W-1:0] low_page_ff;
   logic [PCNT_W-1:0] usable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         low_page_ff  <= PIDX_W'(1);
         usable_ff    <= PCNT_W'(PAGE_COUNT - 1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEAP_BASE: heap_base_ff <= csr_wdata;
            CSR_LOW_PAGE:  low_page_ff  <= csr_wdata[PIDX_W-1:0];
            CSR_USABLE:    usable_ff    <= csr_wdata[PCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Window [win_lo, win_hi)
   logic [PCNT_W:0]   sum_w;
   logic [PCNT_W-1:0] win_hi, win_lo;
   always_comb begin
      sum_w  = {2'b0, low_page_ff} + {1'b0, usable_ff};
      win_hi = (sum_w > (PCNT_W+1)'(PAGE_COUNT)) ? PCNT_W'(PAGE_COUNT) : sum_w[PCNT_W-1:0];
      win_lo = ({1'b0, low_page_ff} < win_hi) ? {1'b0, low_page_ff} : win_hi;
   end

   // Datapath registers
   logic [PCNT_W-1:0] ptr_ff, ptr_in;       // current page
   logic [PCNT_W-1:0] start_ff, start_in;   // run start
   logic [PCNT_W-1:0] last_ff, last_in;     // exclusive end of marked span
   logic [PCNT_W-1:0] need_ff, need_in;     // pages needed
   logic [PCNT_W-1:0] cnt_ff, cnt_in;       // free run length / used count
   logic              mval_ff, mval_in;     // value written to bitmap
   logic              mrun_ff, mrun_in;     // write run length at start page
   logic [1:0]        stat_ff, stat_in;
   logic [31:0]       raddr_ff, raddr_in;
   logic [PCNT_W-1:0] used_ff, used_in;
   logic [31:0]       acnt_ff, acnt_in, rcnt_ff, rcnt_in;
   logic              usage_ff, usage_in;

   // RAM ports
   logic              bm_we, rl_we, bm_wd, bm_rd;
   logic [PIDX_W-1:0] ram_addr;
   logic [PCNT_W-1:0] rl_wd, rl_rd;

   pba_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_bitmap (
      .clock(clock), .we(bm_we), .addr(ram_addr), .wdata(bm_wd), .rdata(bm_rd));
   pba_ram #(.WIDTH(PCNT_W), .DEPTH(PAGE_COUNT)) u_runlen (
      .clock(clock), .we(rl_we), .addr(ram_addr), .wdata(rl_wd), .rdata(rl_rd));

   // Request decode
   logic [31:0] q_size, q_addr, q_end;
   assign q_size = req_tdata[31:0];
   assign q_addr = req_tdata[63:32];
   assign q_end  = req_tdata[95:64];

   logic [33:0] base34, aend34, astart34, hdr34, user34, s34, e34, last34, first34;
   logic [32:0] size33, n33;
   always_comb begin
      base34   = {2'b0, heap_base_ff};
      aend34   = base34 + ({{(34-PCNT_W){1'b0}}, win_hi} << PAGE_BITS);
      astart34 = base34 + ({{(34-PCNT_W){1'b0}}, win_lo} << PAGE_BITS);
      user34   = {2'b0, q_addr};
      hdr34    = user34 - 34'(HDR_BYTES);
      size33   = (q_size == '0) ? 33'd1 : {1'b0, q_size};
      n33      = (size33 + 33'(HDR_BYTES) + 33'((1 << PAGE_BITS) - 1)) >> PAGE_BITS;
      s34      = {2'b0, q_addr} & ~34'((1 << PAGE_BITS) - 1);
      e34      = ({2'b0, q_end} + 34'((1 << PAGE_BITS) - 1)) & ~34'((1 << PAGE_BITS) - 1);
      if (s34 < base34) s34 = base34;
      if (e34 > aend34) e34 = aend34;
      first34  = (s34 - base34) >> PAGE_BITS;
      last34   = (e34 - base34) >> PAGE_BITS;
   end

   logic accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      ptr_in = ptr_ff; start_in = start_ff; last_in = last_ff; need_in = need_ff;
      cnt_in = cnt_ff; mval_in = mval_ff; mrun_in = mrun_ff; stat_in = stat_ff;
      raddr_in = raddr_ff; used_in = used_ff; acnt_in = acnt_ff; rcnt_in = rcnt_ff;
      usage_in = usage_ff;
      bm_we = 1'b0; rl_we = 1'b0; bm_wd = 1'b0; rl_wd = '0;
      ram_addr = ptr_ff[PIDX_W-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            bm_we = 1'b1; rl_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == PCNT_W'(PAGE_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               stat_in = ST_DONE; raddr_in = '0; usage_in = 1'b0;
               unique case (cmd_type'(req_tuser))
                  CMD_ALLOC: begin
                     acnt_in = acnt_ff + 1'b1;
                     if (q_size > 32'hffff_ffff - 32'(HDR_BYTES) ||
                         n33 > 33'(win_hi - win_lo)) begin
                        stat_in = ST_NOSPACE; state_in = S_RESP;
                     end else begin
                        need_in = n33[PCNT_W-1:0];
                        ptr_in = win_lo; start_in = win_lo; cnt_in = '0;
                        state_in = S_AREAD;
                     end
                  end
                  CMD_FREE: begin
                     rcnt_in = rcnt_ff + 1'b1;
                     if (q_addr == '0 || user34 < base34 + 34'(HDR_BYTES) ||
                         user34 >= aend34 || hdr34 < astart34 ||
                         ((hdr34 - astart34) & 34'((1 << PAGE_BITS) - 1)) != '0) begin
                        stat_in = ST_INVALID; state_in = S_RESP;
                     end else begin
                        ptr_in = PCNT_W'((hdr34 - base34) >> PAGE_BITS);
                        state_in = S_FRD;
                     end
                  end
                  CMD_RESERVE: begin
                     if (q_end <= q_addr || aend34 <= base34 ||
                         e34 <= base34 || s34 >= aend34 || q_end == q_addr) begin
                        stat_in = ST_INVALID; state_in = S_RESP;
                     end else begin
                        ptr_in = PCNT_W'(first34); last_in = PCNT_W'(last34);
                        mval_in = 1'b1; mrun_in = 1'b0;
                        state_in = (first34 < last34) ? S_MARK : S_RESP;
                     end
                  end
                  default: begin
                     usage_in = 1'b1; ptr_in = win_lo; cnt_in = '0; used_in = '0;
                     state_in = (win_lo < win_hi) ? S_USE : S_RESP;
                  end
               endcase
               // reserve clip uses original bounds before clamping checks
               if (cmd_type'(req_tuser) == CMD_RESERVE) begin
                  if (((({2'b0, q_end} + 34'((1 << PAGE_BITS) - 1)) &
                        ~34'((1 << PAGE_BITS) - 1)) <= base34) ||
                      (({2'b0, q_addr} & ~34'((1 << PAGE_BITS) - 1)) >= aend34) ||
                      q_end <= q_addr || aend34 <= base34) begin
                     stat_in = ST_INVALID; state_in = S_RESP;
                  end
               end
            end
         end
         S_AREAD: begin
            // address ptr issued this cycle; compare one bit wider so the sum cannot wrap
            if ({1'b0, start_ff} + {1'b0, need_ff} > {1'b0, win_hi}) begin
               stat_in = ST_NOSPACE; state_in = S_RESP;
            end else state_in = S_ACHK;
         end
         S_ACHK: begin
            ram_addr = ptr_ff[PIDX_W-1:0];
            if (bm_rd) begin
               start_in = ptr_ff + 1'b1; cnt_in = '0;
               ptr_in = ptr_ff + 1'b1;
               state_in = S_AREAD;
            end else if (cnt_ff + 1'b1 == need_ff) begin
               ptr_in = start_ff; last_in = start_ff + need_ff;
               mval_in = 1'b1; mrun_in = 1'b1;
               raddr_in = 32'(base34 + ({{(34-PCNT_W){1'b0}}, start_ff} << PAGE_BITS)
                              + 34'(HDR_BYTES));
               state_in = S_MARK;
            end else begin
               cnt_in = cnt_ff + 1'b1; ptr_in = ptr_ff + 1'b1;
               state_in = S_AREAD;
            end
         end
         S_MARK: begin
            bm_we = 1'b1; bm_wd = mval_ff;
            if (ptr_ff == start_ff && mrun_ff) begin
               rl_we = 1'b1; rl_wd = mval_ff ? need_ff : '0;
            end
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff + 1'b1 >= last_ff || ptr_ff == PCNT_W'(PAGE_COUNT - 1))
               state_in = S_RESP;
         end
         S_FRD: state_in = S_FCHK;
         S_FCHK: begin
            if (rl_rd == '0 || {1'b0, ptr_ff} + {1'b0, rl_rd} > {1'b0, win_hi}) begin
               stat_in = ST_INVALID; state_in = S_RESP;
            end else begin
               start_in = ptr_ff; last_in = ptr_ff + rl_rd;
               mval_in = 1'b0; mrun_in = 1'b1;
               state_in = S_MARK;
            end
         end
         S_USE: begin
            // pipelined: read data for ptr-1 arrives while ptr is issued
            if (mval_ff) cnt_in = cnt_ff + PCNT_W'(bm_rd);
            mval_in = 1'b1;
            if (ptr_ff == win_hi) begin
               mval_in = 1'b0; used_in = cnt_ff + PCNT_W'(bm_rd);
               state_in = S_RESP;
            end else ptr_in = ptr_ff + 1'b1;
         end
         S_RESP: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; ptr_ff <= '0; used_ff <= '0;
         acnt_ff <= '0; rcnt_ff <= '0; mval_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ptr_ff <= ptr_in; used_ff <= used_in;
         acnt_ff <= acnt_in; rcnt_ff <= rcnt_in;
         mval_ff <= (state_ff == S_IDLE && state_in == S_USE) ? 1'b0 : mval_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in; last_ff <= last_in; need_ff <= need_in;
      cnt_ff <= cnt_in; mrun_ff <= mrun_in; stat_ff <= stat_in;
      raddr_ff <= raddr_in; usage_ff <= usage_in;
   end

   logic [PCNT_W-1:0] tot;
   assign tot = win_hi - win_lo;

   assign rsp_tvalid = (state_ff == S_RESP);
   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[1:0]     = stat_ff;
      rsp_tdata[33:2]    = (stat_ff == ST_DONE) ? raddr_ff : '0;
      if (usage_ff) begin
         rsp_tdata[47:34]   = tot;
         rsp_tdata[61:48]   = used_ff;
         rsp_tdata[75:62]   = tot - used_ff;
         rsp_tdata[107:76]  = acnt_ff;
         rsp_tdata[139:108] = rcnt_ff;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("response dropped");
   a_no_mark_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FCHK) |-> $past(state_ff) == S_FRD) else $error("free sequence");
endmodule
`default_nettype wire

>>> verif/page_bitmap_allocator_tb.sv
// Self-checking testbench for page_bitmap_allocator: a directed table, then random
// phases under several heap settings, each checked against a built-in allocator model.
// Depends on pba_pkg and the design files only.
`timescale 1ns / 100ps
module page_bitmap_allocator_tb
   import pba_pkg::*;
();

   typedef struct packed {
      status_type  status;
      logic [31:0] ret_addr;
      logic [13:0] total_pg;
      logic [13:0] used_pg;
      logic [13:0] free_pg;
      logic [31:0] alloc_cnt;
      logic [31:0] release_cnt;
   } rsp_t;

   // one directed row; want is used only when known is set
   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] size_b;
      logic [31:0] addr_b;
      logic [31:0] end_b;
      bit          known;
      rsp_t        want;
   } row_t;

   localparam rsp_t NONE = '0;
   localparam int N_ROWS = 22;
   // reset window is pages [1, 8192) with heap at address zero
   localparam row_t DIRECTED [N_ROWS] = '{
      '{CMD_USAGE,   32'h0,        32'h0,        32'h0,        1'b1,
        '{ST_DONE, 32'h0, 14'd8191, 14'd0, 14'd8191, 32'd0, 32'd0}},
      '{CMD_ALLOC,   32'h0,        32'h0,        32'h0,        1'b1,
        '{ST_DONE, 32'h1010, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_ALLOC,   32'hFFFFFFF0, 32'h0,        32'h0,        1'b1,
        '{ST_NOSPACE, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_ALLOC,   32'hFFFFFFFF, 32'h0,        32'h0,        1'b1,
        '{ST_NOSPACE, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_ALLOC,   32'd4080,     32'h0,        32'h0,        1'b1,
        '{ST_DONE, 32'h2010, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_ALLOC,   32'd4081,     32'h0,        32'h0,        1'b1,
        '{ST_DONE, 32'h3010, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_FREE,    32'h0,        32'h0,        32'h0,        1'b1,
        '{ST_INVALID, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_FREE,    32'h0,        32'h2010,     32'h0,        1'b1,
        '{ST_DONE, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_FREE,    32'h0,        32'h2010,     32'h0,        1'b1,
        '{ST_INVALID, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_FREE,    32'h0,        32'h3011,     32'h0,        1'b1,
        '{ST_INVALID, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_FREE,    32'h0,        32'h10,       32'h0,        1'b1,
        '{ST_INVALID, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_FREE,    32'h0,        32'hFFFFFFFF, 32'h0,        1'b1,
        '{ST_INVALID, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_ALLOC,   32'd1,        32'h0,        32'h0,        1'b1,
        '{ST_DONE, 32'h2010, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_RESERVE, 32'h0,        32'h5000,     32'h5000,     1'b1,
        '{ST_INVALID, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_RESERVE, 32'h0,        32'h6000,     32'h5000,     1'b1,
        '{ST_INVALID, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_RESERVE, 32'h0,        32'h5001,     32'h6001,     1'b0, NONE},
      '{CMD_RESERVE, 32'h0,        32'h0,        32'h1000,     1'b0, NONE},
      '{CMD_RESERVE, 32'h0,        32'hFFFFF000, 32'hFFFFFFFF, 1'b1,
        '{ST_INVALID, 32'h0, 14'd0, 14'd0, 14'd0, 32'd0, 32'd0}},
      '{CMD_ALLOC,   32'd1,        32'h0,        32'h0,        1'b0, NONE},
      '{CMD_FREE,    32'h0,        32'h3010,     32'h0,        1'b0, NONE},
      '{CMD_ALLOC,   32'hFFFFFFEF, 32'h0,        32'h0,        1'b0, NONE},
      '{CMD_USAGE,   32'h0,        32'h0,        32'h0,        1'b0, NONE}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [95:0]   req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [143:0]  rsp_tdata;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [31:0]   csr_wdata = '0;

   page_bitmap_allocator u_top (.*);

   always #5 clock = ~clock;

   // allocator model state
   bit          pg_used [PAGE_COUNT];
   int unsigned pg_run  [PAGE_COUNT];
   logic [31:0] m_heap_base = 32'h0;
   int unsigned m_first = 1;
   int unsigned m_usable = 8191;
   logic [31:0] n_alloc = 0;
   logic [31:0] n_release = 0;

   rsp_t        pending_rsp [$];   // expected responses, oldest first
   logic [31:0] live_addr [$];     // user addresses of allocations still held
   bit          failed = 1'b0;
   bit          calm = 1'b0;       // no idling on either side
   int          rsp_stall = 0;

   function automatic void win_bounds(output int unsigned lo, output int unsigned hi);
      hi = m_first + m_usable;
      if (hi > PAGE_COUNT) hi = PAGE_COUNT;
      lo = (m_first < hi) ? m_first : hi;
   endfunction

   function automatic longint unsigned page_byte(int unsigned pg);
      return longint'(m_heap_base) + (longint'(pg) << PAGE_BITS);
   endfunction

   // advance the model by one request and return its response
   function automatic rsp_t allocator_step(cmd_type cmd, logic [31:0] sz,
                                           logic [31:0] a0, logic [31:0] a1);
      rsp_t r;
      int unsigned lo, hi, pg, j, run, used;
      longint unsigned s, e, n, hb, astart, aend, hdr, mask;
      bit clear;
      r = '0;
      r.status = ST_DONE;
      win_bounds(lo, hi);
      hb = m_heap_base;
      mask = (64'd1 << PAGE_BITS) - 1;
      astart = page_byte(lo);
      aend = page_byte(hi);
      case (cmd)
         CMD_ALLOC: begin
            n_alloc++;
            s = (sz == 0) ? 1 : sz;
            r.status = ST_NOSPACE;
            if (s <= 64'hFFFFFFEF) begin
               n = (s + HDR_BYTES + mask) >> PAGE_BITS;
               if (n != 0 && n <= hi - lo) begin
                  pg = lo;
                  while (pg + n <= hi && r.status != ST_DONE) begin
                     clear = 1'b1;
                     for (j = 0; j < n; j++)
                        if (pg_used[pg + j]) begin
                           clear = 1'b0;
                           break;
                        end
                     if (!clear) pg += j + 1;
                     else begin
                        for (j = 0; j < n; j++) pg_used[pg + j] = 1'b1;
                        pg_run[pg] = n;
                        r.status = ST_DONE;
                        r.ret_addr = 32'(page_byte(pg) + HDR_BYTES);
                     end
                  end
               end
            end
         end
         CMD_FREE: begin
            n_release++;
            r.status = ST_INVALID;
            if (a0 != 0 && a0 >= hb + HDR_BYTES && a0 < aend) begin
               hdr = a0 - HDR_BYTES;
               if (hdr >= astart && hdr < aend && ((hdr - astart) & mask) == 0) begin
                  pg = (hdr - hb) >> PAGE_BITS;
                  run = pg_run[pg];
                  if (pg >= lo && pg < hi && run != 0 && pg + run <= hi) begin
                     for (j = 0; j < run; j++) pg_used[pg + j] = 1'b0;
                     pg_run[pg] = 0;
                     r.status = ST_DONE;
                  end
               end
            end
         end
         CMD_RESERVE: begin
            r.status = ST_INVALID;
            s = longint'(a0) & ~mask;
            e = (longint'(a1) + mask) & ~mask;
            if (a1 > a0 && aend > hb && e > hb && s < aend) begin
               if (s < hb) s = hb;
               if (e > aend) e = aend;
               for (n = (s - hb) >> PAGE_BITS; n < ((e - hb) >> PAGE_BITS) && n < PAGE_COUNT;
                    n++)
                  pg_used[n] = 1'b1;
               r.status = ST_DONE;
            end
         end
         default: begin
            used = 0;
            for (pg = lo; pg < hi; pg++) used += pg_used[pg];
            r.total_pg = 14'(hi - lo);
            r.used_pg = 14'(used);
            r.free_pg = 14'(hi - lo - used);
            r.alloc_cnt = n_alloc;
            r.release_cnt = n_release;
         end
      endcase
      return r;
   endfunction

   // hand one request to the block and log the expected response on acceptance
   task automatic send_request(cmd_type cmd, logic [31:0] sz, logic [31:0] a0,
                               logic [31:0] a1, bit known, rsp_t want);
      rsp_t r;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {a1, a0, sz};
      do @(posedge clock); while (!req_tready);
      r = allocator_step(cmd, sz, a0, a1);
      if (cmd == CMD_ALLOC && r.status == ST_DONE) live_addr.push_back(r.ret_addr);
      pending_rsp.push_back(known ? want : r);
   endtask

   // random request biased toward the current window: frees are mostly real frees of live blocks
   task automatic random_request();
      int unsigned lo, hi, pick, k;
      logic [31:0] sz, a0, a1, ws;
      cmd_type cmd;
      win_bounds(lo, hi);
      ws = 32'(page_byte(lo));
      sz = 0;
      a0 = $urandom;
      a1 = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         cmd = CMD_ALLOC;
         k = $urandom_range(0, 99);
         if (k < 5) sz = $urandom;
         else if (k < 8) sz = 32'hFFFFFFE0 + $urandom_range(0, 31);
         else sz = $urandom_range(0, 3 * 4096);
      end else if (pick < 70) begin
         cmd = CMD_FREE;
         k = $urandom_range(0, 99);
         if (live_addr.size() > 0 && k < 75) begin
            pick = $urandom_range(0, live_addr.size() - 1);
            a0 = live_addr[pick];
            live_addr.delete(pick);
         end else if (live_addr.size() > 0 && k < 90) begin
            a0 = live_addr[$urandom_range(0, live_addr.size() - 1)]
                 + $urandom_range(0, 2) * 4096 - $urandom_range(0, 16);
         end else if (k < 95) begin
            a0 = 0;
         end
      end else if (pick < 85) begin
         cmd = CMD_RESERVE;
         if ($urandom_range(0, 19) != 0) begin
            a0 = ws - 2 * 4096 + $urandom_range(0, 6 * 4096);
            a1 = ($urandom_range(0, 9) == 0) ? a0 - $urandom_range(0, 4096)
                                            : a0 + $urandom_range(1, 2 * 4096);
         end
      end else begin
         cmd = CMD_USAGE;
      end
      send_request(cmd, sz, a0, a1, 1'b0, NONE);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // one write, then the enable is dropped before the next one
   task automatic write_csr(csr_type idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_HEAP_BASE: m_heap_base = value;
         CSR_LOW_PAGE:  m_first = value & 32'h1FFF;
         default:       m_usable = value & 32'h3FFF;
      endcase
      @(posedge clock);
   endtask

   // response side: random stall bursts, compare each response with the oldest expectation
   always @(posedge clock) begin
      rsp_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = status_type'(rsp_tdata[1:0]);
         got.ret_addr    = rsp_tdata[33:2];
         got.total_pg    = rsp_tdata[47:34];
         got.used_pg     = rsp_tdata[61:48];
         got.free_pg     = rsp_tdata[75:62];
         got.alloc_cnt   = rsp_tdata[107:76];
         got.release_cnt = rsp_tdata[139:108];
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            failed = 1'b1;
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               failed = 1'b1;
            end
            if (got.ret_addr !== want.ret_addr) begin
               $error("result_address: expected %h, got %h", want.ret_addr, got.ret_addr);
               failed = 1'b1;
            end
            if (got.total_pg !== want.total_pg) begin
               $error("window_pages: expected %0d, got %0d", want.total_pg, got.total_pg);
               failed = 1'b1;
            end
            if (got.used_pg !== want.used_pg) begin
               $error("busy_pages: expected %0d, got %0d", want.used_pg, got.used_pg);
               failed = 1'b1;
            end
            if (got.free_pg !== want.free_pg) begin
               $error("idle_pages: expected %0d, got %0d", want.free_pg, got.free_pg);
               failed = 1'b1;
            end
            if (got.alloc_cnt !== want.alloc_cnt) begin
               $error("alloc_calls: expected %0d, got %0d", want.alloc_cnt, got.alloc_cnt);
               failed = 1'b1;
            end
            if (got.release_cnt !== want.release_cnt) begin
               $error("release_calls: expected %0d, got %0d",
                      want.release_cnt, got.release_cnt);
               failed = 1'b1;
            end
         end
      end
      if (rsp_stall > 0) rsp_stall--;
      else if (!calm && $urandom_range(0, 19) == 0) rsp_stall = $urandom_range(1, 16);
      rsp_tready <= (rsp_stall == 0);
   end

   // heap settings per phase: heap base, lowest allocatable page, page count, request count.
   // Small windows carry most traffic; whole-heap windows get only a few requests
   // since every alloc and usage query walks the window.
   localparam int N_PH = 9;
   logic [31:0] ph_base  [N_PH] = '{32'h0001_0000, 32'hFFFF_F000, 32'h1234_5678,
                                    32'h0000_0000, 32'h8000_0000, 32'h0000_0000,
                                    32'h7FFF_F000, 32'h0000_0000, 32'h0000_3000};
   int unsigned ph_first [N_PH] = '{4, 0, 9, 8191, 100, 0, 0, 8191, 20};
   int unsigned ph_usable[N_PH] = '{24, 16, 20, 1, 8192, 8192, 32, 8192, 40};
   int unsigned ph_count [N_PH] = '{380, 300, 280, 80, 12, 10, 350, 40, 550};

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table at reset settings; the block first clears its RAMs
      for (int i = 0; i < N_ROWS; i++)
         send_request(DIRECTED[i].cmd, DIRECTED[i].size_b, DIRECTED[i].addr_b,
                      DIRECTED[i].end_b, DIRECTED[i].known, DIRECTED[i].want);
      drain();

      for (int p = 0; p < N_PH; p++) begin
         if (p == N_PH - 1) calm = 1'b1;
         write_csr(CSR_HEAP_BASE, ph_base[p]);
         write_csr(CSR_LOW_PAGE, ph_first[p]);
         write_csr(CSR_USABLE, ph_usable[p]);
         // blocks handed out under the old base are kept: freeing them probes bad addresses
         for (int i = 0; i < ph_count[p]; i++) begin
            if (p == 0 && i == ph_count[p] / 2) begin
               // sender holds off until the block has answered everything
               req_tvalid <= 1'b0;
               while (pending_rsp.size() != 0) @(posedge clock);
            end
            random_request();
         end
         drain();
      end

      repeat (100) @(posedge clock);
      if (!failed && pending_rsp.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #200ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
